// ===== sv/rrq_pkg.sv =====
// Shared constants, types and helpers for the round-robin quantum scheduler.
package rrq_pkg;

    // Depth of the ready queue and number of task slots
    localparam int MAX_TASKS  = 16;
    localparam int SLOT_COUNT = 16;

    localparam int SLOT_W  = 4;
    localparam int TIME_W  = 8;
    localparam int QUANT_W = 8;
    localparam int HEAD_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W   = $clog2(MAX_TASKS + 1);
    localparam int SUM_W   = HEAD_W + 1;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Register index of the quantum register
    localparam logic [0:0] REG_QUANTUM = 1'b0;
    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd4;

    // Input commands
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_SLOT,
        ST_RD_CNT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              add_rejected;
        logic              queue_empty;
        logic              task_done;
        logic [SLOT_W-1:0] ran_task;
        logic              ran_valid;
    } result_t;

    typedef struct packed {
        logic [TIME_W-1:0]  time_left;
        logic [QUANT_W-1:0] quantum_left;
    } counters_t;

    // Fold a position below twice the depth back into the queue
    function automatic logic [HEAD_W-1:0] wrap_pos(input logic [SUM_W-1:0] pos);
        logic [SUM_W-1:0] folded;
        begin
            if (pos >= SUM_W'(MAX_TASKS)) begin
                folded = pos - SUM_W'(MAX_TASKS);
            end else begin
                folded = pos;
            end
            wrap_pos = folded[HEAD_W-1:0];
        end
    endfunction

endpackage

// ===== sv/round_robin_quantum_scheduler.sv =====
// Round-robin tick scheduler with a time quantum over a FIFO ready queue.
//
//  channel  | direction | handshake          | contents
//  ---------+-----------+--------------------+--------------------------------------------
//  s_       | in        | s_tvalid/s_tready  | add or tick request
//  m_       | out       | m_tvalid/m_tready  | one result per request
//  apb      | in        | psel/penable       | quantum register at byte address 0
//
// A tick that runs a task steps through accept, a read of the queue memory at the
// head, a read of the slot counter memory and the write back; an add or an idle
// tick goes from accept straight to the finish state.
// Reset clears state, head, count, quantum and the output valid flag; the memories
// need no clearing pass. A request is taken while a result still waits on m_;
// the next result then holds in the finish state until the output register frees.
module round_robin_quantum_scheduler
    import rrq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    // [3:0] task_id, [11:4] run_time, [15:12] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    // [0] command
    input  logic                s_tuser,

    output logic                m_tvalid,
    input  logic                m_tready,
    // [0] ran_valid, [4:1] ran_task, [5] task_done, [6] queue_empty,
    // [7] add_rejected
    output logic [M_DATA_W-1:0] m_tdata,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    // Memories: ready queue of slots and per-slot counters
    logic [SLOT_W-1:0] ready_mem [MAX_TASKS];
    counters_t         cnt_mem   [SLOT_COUNT];

    state_t             state_reg, state_next;
    logic [HEAD_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [QUANT_W-1:0] quantum_reg;
    result_t            res_reg, res_next;
    result_t            out_reg;
    logic               out_valid_reg;

    logic [SLOT_W-1:0]  slot_rdata_reg;
    counters_t          cnt_rdata_reg;

    logic               rq_we;
    logic [HEAD_W-1:0]  rq_waddr;
    logic [SLOT_W-1:0]  rq_wdata;
    logic               cnt_we;
    logic [SLOT_W-1:0]  cnt_waddr;
    counters_t          cnt_wdata;

    logic               s_accept;
    logic               out_free;
    logic               cfg_write;
    logic [HEAD_W-1:0]  tail_pos;
    logic [HEAD_W-1:0]  head_inc;
    logic [SLOT_W-1:0]  in_task_id;
    logic [TIME_W-1:0]  in_run_time;
    logic [TIME_W-1:0]  time_dec;
    logic [QUANT_W-1:0] quant_dec;

    assign in_task_id  = s_tdata[SLOT_W-1:0];
    assign in_run_time = s_tdata[SLOT_W +: TIME_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    assign tail_pos = wrap_pos(SUM_W'(head_reg) + SUM_W'(count_reg));
    assign head_inc = wrap_pos(SUM_W'(head_reg) + SUM_W'(1));

    // Saturating countdown of the head task's counters
    assign time_dec  = (cnt_rdata_reg.time_left != '0) ?
                       cnt_rdata_reg.time_left - TIME_W'(1) : '0;
    assign quant_dec = (cnt_rdata_reg.quantum_left != '0) ?
                       cnt_rdata_reg.quantum_left - QUANT_W'(1) : '0;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_QUANTUM);
    assign prdata    = (paddr[2] == REG_QUANTUM) ? PDATA_W'(quantum_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg <= QUANTUM_RESET;
        end else if (cfg_write) begin
            quantum_reg <= pwdata[QUANT_W-1:0];
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == CMD_TICK && count_reg != '0) begin
                        state_next = ST_RD_SLOT;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_RD_SLOT: state_next = ST_RD_CNT;
            ST_RD_CNT:  state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Queue update, memory writes and result
    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        res_next   = res_reg;
        rq_we      = 1'b0;
        rq_waddr   = tail_pos;
        rq_wdata   = in_task_id;
        cnt_we     = 1'b0;
        cnt_waddr  = in_task_id;
        cnt_wdata  = '{time_left: in_run_time, quantum_left: quantum_reg};
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    res_next = '0;
                    if (s_tuser == CMD_ADD) begin
                        if (count_reg == CNT_W'(MAX_TASKS)) begin
                            res_next.add_rejected = 1'b1;
                        end else begin
                            rq_we      = 1'b1;
                            cnt_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    res_next.queue_empty = (count_next == '0);
                end
            end
            ST_RD_CNT: begin
                cnt_we             = 1'b1;
                cnt_waddr          = slot_rdata_reg;
                cnt_wdata          = '{time_left: time_dec, quantum_left: quant_dec};
                res_next.ran_valid = 1'b1;
                res_next.ran_task  = slot_rdata_reg;
                priority if (time_dec == '0) begin
                    // finished: drop from the head
                    res_next.task_done = 1'b1;
                    head_next          = head_inc;
                    count_next         = count_reg - CNT_W'(1);
                end else if (quant_dec == '0) begin
                    // quantum spent: reload and rotate to the tail
                    cnt_wdata.quantum_left = quantum_reg;
                    rq_we                  = 1'b1;
                    rq_wdata               = slot_rdata_reg;
                    head_next              = head_inc;
                end else begin
                    head_next = head_reg;
                end
                res_next.queue_empty = (count_next == '0);
            end
            ST_RD_SLOT, ST_FINISH: begin
                res_next = res_reg;
            end
            default: begin
                res_next = res_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (state_reg == ST_FINISH && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (state_reg == ST_FINISH && out_free) begin
            out_reg <= res_reg;
        end
    end

    // Ready queue memory: read at the head, write at the tail
    always_ff @(posedge aclk) begin
        if (rq_we) begin
            ready_mem[rq_waddr] <= rq_wdata;
        end
        slot_rdata_reg <= ready_mem[head_reg];
    end

    // Slot counter memory: read at the slot fetched from the queue
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata_reg <= cnt_mem[slot_rdata_reg];
    end

endmodule

// ===== bench/rrq_result_checker.sv =====
// Watches the scheduler channels, predicts every result and compares it with the block's output.
module rrq_result_checker
    import rrq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic [PDATA_W-1:0]  prdata,
    input  logic                pready,
    output int                  mismatches,
    output int                  awaiting
);

    localparam logic [PADDR_W-1:0] QUANTUM_ADDR = PADDR_W'(4 * int'(REG_QUANTUM));

    // Predicted scheduler state
    logic [SLOT_W-1:0]  slot_fifo [MAX_TASKS];
    logic [HEAD_W-1:0]  fifo_head;
    logic [CNT_W-1:0]   fifo_count;
    logic [TIME_W-1:0]  remaining [SLOT_COUNT];
    logic [QUANT_W-1:0] slice_left [SLOT_COUNT];
    logic [QUANT_W-1:0] quantum_reg;

    // Results still owed by the block, oldest first
    result_t owed_results [$];
    int      err_count;

    assign mismatches = err_count;

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("MISMATCH at %0t: %s expected %0d got %0d", $time, what, want, got);
        err_count++;
    endtask

    // Apply one request to the predicted state and return the result it causes
    function automatic result_t schedule_step(input logic cmd, input logic [SLOT_W-1:0] id,
                                              input logic [TIME_W-1:0] run);
        result_t           res;
        logic [SLOT_W-1:0] slot;
        logic [HEAD_W-1:0] tail;
        res  = '0;
        tail = fifo_head + fifo_count[HEAD_W-1:0];
        if (cmd == CMD_ADD) begin
            if (fifo_count >= CNT_W'(MAX_TASKS)) begin
                res.add_rejected = 1'b1;
            end else begin
                slot_fifo[tail] = id;
                fifo_count      = fifo_count + 1'b1;
                remaining[id]   = run;
                slice_left[id]  = quantum_reg;
            end
        end else if (fifo_count != '0) begin
            slot         = slot_fifo[fifo_head];
            res.ran_valid = 1'b1;
            res.ran_task  = slot;
            // Both counters stop at zero
            if (remaining[slot] != '0) remaining[slot] = remaining[slot] - 1'b1;
            if (slice_left[slot] != '0) slice_left[slot] = slice_left[slot] - 1'b1;
            if (remaining[slot] == '0) begin
                res.task_done = 1'b1;
                fifo_head     = fifo_head + 1'b1;
                fifo_count    = fifo_count - 1'b1;
            end else if (slice_left[slot] == '0) begin
                // Reload the slice and move the head entry to the tail
                slice_left[slot] = quantum_reg;
                slot_fifo[tail]  = slot;
                fifo_head        = fifo_head + 1'b1;
            end
        end
        res.queue_empty = (fifo_count == '0);
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        result_t want;
        result_t got;
        if (!aresetn) begin
            fifo_head   = '0;
            fifo_count  = '0;
            quantum_reg = QUANTUM_RESET;
            owed_results.delete();
            awaiting   <= 0;
        end else begin
            // Compare the result first: it can never belong to this edge's request
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (owed_results.size() == 0) begin
                    report_mismatch("result with nothing owed, tdata", 0, int'(m_tdata));
                end else begin
                    want = owed_results.pop_front();
                    if (got.ran_valid !== want.ran_valid)
                        report_mismatch("ran_valid", want.ran_valid, got.ran_valid);
                    if (got.ran_task !== want.ran_task)
                        report_mismatch("ran_task", want.ran_task, got.ran_task);
                    if (got.task_done !== want.task_done)
                        report_mismatch("task_done", want.task_done, got.task_done);
                    if (got.queue_empty !== want.queue_empty)
                        report_mismatch("queue_empty", want.queue_empty, got.queue_empty);
                    if (got.add_rejected !== want.add_rejected)
                        report_mismatch("add_rejected", want.add_rejected, got.add_rejected);
                end
            end

            // Predict the result of an accepted request
            if (s_tvalid && s_tready) begin
                owed_results.push_back(schedule_step(s_tuser, s_tdata[SLOT_W-1:0],
                                                     s_tdata[SLOT_W+TIME_W-1:SLOT_W]));
            end

            // Track register writes and check read data
            if (psel && penable && pready && paddr == QUANTUM_ADDR) begin
                if (pwrite) begin
                    quantum_reg = pwdata[QUANT_W-1:0];
                end else if (prdata !== PDATA_W'(quantum_reg)) begin
                    report_mismatch("quantum readback", int'(quantum_reg), int'(prdata));
                end
            end

            awaiting <= owed_results.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Stimulus and verdict for the round-robin quantum scheduler, with the result checker beside it.
module testbench;
    import rrq_pkg::*;

    localparam logic [PADDR_W-1:0] QUANTUM_ADDR = PADDR_W'(4 * int'(REG_QUANTUM));
    localparam int PHASE_COUNT = 7;
    localparam int PHASE_ITEMS = 270;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tready = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [PDATA_W-1:0]  pwdata   = '0;

    logic                s_tready;
    logic                m_tvalid;
    logic [M_DATA_W-1:0] m_tdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int mismatches;
    int awaiting;
    int sent_adds;
    int sent_ticks;
    int settings_used;
    int sink_hold;
    bit steady;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    round_robin_quantum_scheduler i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rrq_result_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    // Short run times keep tasks finishing; the extremes show up now and then
    function automatic logic [TIME_W-1:0] pick_run_time();
        int r;
        r = $urandom_range(99);
        if (r < 4) return '0;
        if (r < 8) return '1;
        if (r < 18) return TIME_W'($urandom_range(128, 254));
        return TIME_W'($urandom_range(1, 12));
    endfunction

    // Stall the result channel at random; no new stall starts while steady
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else if (m_tready && !steady) begin
            m_tready  <= 1'b0;
            sink_hold <= pick_gap();
        end else begin
            m_tready  <= 1'b1;
            sink_hold <= $urandom_range(0, 12);
        end
    end

    // Offer one request after a random gap and hold it until accepted
    task automatic send_request(input logic cmd, input logic [SLOT_W-1:0] id,
                                input logic [TIME_W-1:0] run);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_DATA_W - SLOT_W - TIME_W){1'b0}}, run, id};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_ADD) sent_adds++;
        else sent_ticks++;
    endtask

    // One register access: setup cycle, then access until pready
    task automatic reg_access(input logic wr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= QUANTUM_ADDR;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Drop valid and wait until every owed result has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaiting != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [QUANT_W-1:0] phase_quanta [PHASE_COUNT];
        int                 items_left;
        int                 burst;
        int                 add_bias;
        logic               cmd;

        phase_quanta = '{8'd4, 8'd1, 8'd255, 8'd0, 8'd2, 8'd0, 8'd3};
        phase_quanta[5] = QUANT_W'($urandom_range(1, 255));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset value of the quantum register
        reg_access(1'b0, '0);
        settings_used = 1;

        // Idle tick with junk in the ignored fields
        send_request(CMD_TICK, 4'hA, 8'h5A);
        // Fill the queue: zero, one and full run times, and one slot queued twice
        for (int i = 0; i < MAX_TASKS; i++) begin
            send_request(CMD_ADD, (i == 14) ? SLOT_W'(5) : SLOT_W'(i),
                         (i == 0) ? 8'd0 : (i == 1) ? 8'd1 : (i == 2) ? 8'd255 :
                         TIME_W'($urandom_range(1, 6)));
        end
        // Add on a full queue
        send_request(CMD_ADD, 4'd9, 8'd7);
        // Finish early tasks, then run the long one through a rotation
        repeat (7) send_request(CMD_TICK, SLOT_W'($urandom), TIME_W'($urandom));
        drain();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p > 0) begin
                reg_access(1'b1, PDATA_W'(phase_quanta[p]));
                reg_access(1'b0, '0);
                settings_used++;
            end
            items_left = PHASE_ITEMS;
            while (items_left > 0) begin
                // Bursts lean toward adds or ticks so the queue fills and empties
                burst    = $urandom_range(20, 60);
                add_bias = ($urandom_range(2) == 0) ? 25 : ($urandom_range(1) ? 50 : 72);
                steady   = ($urandom_range(3) == 0);
                while (burst > 0 && items_left > 0) begin
                    cmd = ($urandom_range(99) < add_bias) ? CMD_ADD : CMD_TICK;
                    send_request(cmd, SLOT_W'($urandom), pick_run_time());
                    burst--;
                    items_left--;
                end
            end
            steady = 1'b0;
            drain();
        end

        repeat (20) @(posedge aclk);
        $display("Summary: %0d adds and %0d ticks under %0d quantum settings,",
                 sent_adds, sent_ticks, settings_used);
        $display("         including a full queue, zero quantum and random stalls on both sides");
        if (mismatches == 0 && awaiting == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
